### hw/rtl/tcpu_pkg.sv
// Shared opcodes, ALU selects, jump conditions, status codes and the result type for the tiny CPU core.
package tcpu_pkg;

    // Major opcodes from the top nibble of the instruction word.
    localparam logic [3:0] OP_ILLEGAL = 4'h0;
    localparam logic [3:0] OP_SET     = 4'h1;
    localparam logic [3:0] OP_LOAD    = 4'h2;
    localparam logic [3:0] OP_STORE   = 4'h3;
    localparam logic [3:0] OP_MOVE    = 4'h4;
    localparam logic [3:0] OP_ALU     = 4'h5;
    localparam logic [3:0] OP_JMPC    = 4'h6;
    localparam logic [3:0] OP_JMPR    = 4'h7;
    localparam logic [3:0] OP_CALLC   = 4'h8;
    localparam logic [3:0] OP_CALLR   = 4'h9;
    localparam logic [3:0] OP_RET     = 4'hA;
    localparam logic [3:0] OP_PUSH    = 4'hB;
    localparam logic [3:0] OP_POP     = 4'hC;
    localparam logic [3:0] OP_IN      = 4'hD;
    localparam logic [3:0] OP_OUT     = 4'hE;
    localparam logic [3:0] OP_HALT    = 4'hF;

    // ALU selects.
    localparam logic [2:0] ALU_ADD  = 3'd0;
    localparam logic [2:0] ALU_SUB  = 3'd1;
    localparam logic [2:0] ALU_AND  = 3'd2;
    localparam logic [2:0] ALU_OR   = 3'd3;
    localparam logic [2:0] ALU_XOR  = 3'd4;
    localparam logic [2:0] ALU_SHR  = 3'd5;
    localparam logic [2:0] ALU_CMP  = 3'd6;
    localparam logic [2:0] ALU_TEST = 3'd7;

    // Jump conditions.
    localparam logic [2:0] COND_ALWAYS = 3'd0;
    localparam logic [2:0] COND_ZERO   = 3'd1;
    localparam logic [2:0] COND_NZERO  = 3'd2;
    localparam logic [2:0] COND_NEG    = 3'd3;
    localparam logic [2:0] COND_GT     = 3'd4;
    localparam logic [2:0] COND_LE     = 3'd5;
    localparam logic [2:0] COND_NNEG   = 3'd6;

    // Result status codes.
    localparam logic [1:0] ST_RUN     = 2'd0;
    localparam logic [1:0] ST_HALTED  = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;

    localparam logic [3:0] MOVE_SP = 4'd8;

    // One result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pc_after;
        logic        out_valid;
        logic [7:0]  out_char;
        logic        in_taken;
    } result_t;

endpackage

### hw/rtl/tcpu_alu.sv
// Shared 16-bit arithmetic, logic and shift unit of the tiny CPU core.
module tcpu_alu (
    input  logic [2:0]  sel,
    input  logic [15:0] a,
    input  logic [15:0] b,
    output logic [15:0] val
);
    import tcpu_pkg::*;

    // One operation per cycle; CMP matches SUB and TEST passes a through.
    always_comb
    begin
        case (sel)
            ALU_ADD: val = a + b;
            ALU_SUB: val = a - b;
            ALU_AND: val = a & b;
            ALU_OR:  val = a | b;
            ALU_XOR: val = a ^ b;
            ALU_SHR: val = (b[15:4] != 12'd0) ? 16'd0 : (a >> b[3:0]);
            ALU_CMP: val = a - b;
            default: val = a;
        endcase
    end
endmodule

### hw/rtl/tiny_16bit_cpu_core_top.sv
// Top level of the tiny 16-bit CPU core: sequencer, register file and memory.
//
// Channel | Direction | Handshake           | Payload
// request | in        | in_valid/in_ready   | operation, load_address, load_byte, in_char, in_eof
// result  | out       | res_valid/res_ready | status, pc_after, out_valid, out_char, in_taken
//
// A byte load presents its result through the S_WAIT state. An instruction passes through
// the fetch states (instruction word and constant word, always fetched), the execute state,
// the data states through the single memory port (word read D0-D2, byte read D0-D1, word
// write W0-W1, byte write W0, none for other instructions) and the retire state.
// Reset clears the registers, SP, PC and flags; memory is not cleared.
// A new request is taken only after the previous result has been accepted.
module tiny_16bit_cpu_core_top #(
    parameter int MEM_ADDR_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [15:0] load_address,
    input  logic [7:0]  load_byte,
    input  logic [7:0]  in_char,
    input  logic        in_eof,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [1:0]  status,
    output logic [15:0] pc_after,
    output logic        out_valid,
    output logic [7:0]  out_char,
    output logic        in_taken
);
    import tcpu_pkg::*;

    localparam int MemDepth = 1 << MEM_ADDR_BITS;

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_I0    = 4'd1;  // insn low byte returning
    localparam logic [3:0] S_I1    = 4'd2;  // insn high byte returning
    localparam logic [3:0] S_K0    = 4'd3;  // constant low byte returning
    localparam logic [3:0] S_K1    = 4'd4;  // constant high byte returning
    localparam logic [3:0] S_EXEC  = 4'd5;
    localparam logic [3:0] S_D0    = 4'd6;  // data low byte read issued
    localparam logic [3:0] S_D1    = 4'd7;  // data low byte returning
    localparam logic [3:0] S_D2    = 4'd8;  // data high byte returning
    localparam logic [3:0] S_W0    = 4'd9;  // low store byte
    localparam logic [3:0] S_W1    = 4'd10; // high store byte
    localparam logic [3:0] S_DONE  = 4'd11;
    localparam logic [3:0] S_WAIT  = 4'd12; // program byte written

    logic [7:0] mem [MemDepth];
    logic [MEM_ADDR_BITS-1:0] maddr;
    logic [7:0] mwdata;
    logic       mwe;
    logic [7:0] mrdata_reg;

    logic [3:0]  state_reg, state_next;
    logic [15:0] regs_reg [8];
    logic [15:0] pc_reg, sp_reg;
    logic        z_reg, n_reg;
    logic [15:0] insn_reg, kval_reg, dval_reg, addr_reg, wdata_reg;
    logic        eof_reg;
    logic [7:0]  char_reg;
    logic        res_valid_reg;
    result_t     res_reg;

    logic [3:0]  opc;
    logic [2:0]  ra, rb, cond;
    logic        byte_mode, via_reg;
    logic [15:0] rva, rvb, alu_val;
    logic        cond_ok;
    logic [15:0] kaddr;
    logic        is_rd, is_wr;
    logic [15:0] pc_done;
    logic [1:0]  st_done;
    logic        outv_done;
    logic [7:0]  char_done;
    logic        take_done;

    // Memory with one port and registered read data.
    always_ff @(posedge clk)
    begin
        if (mwe)
        begin
            mem[maddr] <= mwdata;
        end
        mrdata_reg <= mem[maddr];
    end

    // Decode fields of the latched instruction.
    assign opc       = insn_reg[15:12];
    assign ra        = insn_reg[2:0];
    assign rb        = insn_reg[5:3];
    assign cond      = insn_reg[11:9];
    assign byte_mode = insn_reg[10];
    assign via_reg   = insn_reg[11];
    assign rva       = regs_reg[ra];
    assign rvb       = regs_reg[rb];
    assign kaddr     = via_reg ? rvb : kval_reg;

    tcpu_alu u_alu (
        .sel (insn_reg[11:9]),
        .a   (rva),
        .b   (rvb),
        .val (alu_val)
    );

    always_comb
    begin
        case (cond)
            COND_ALWAYS: cond_ok = 1'b1;
            COND_ZERO:   cond_ok = z_reg;
            COND_NZERO:  cond_ok = !z_reg;
            COND_NEG:    cond_ok = n_reg;
            COND_GT:     cond_ok = !n_reg && !z_reg;
            COND_LE:     cond_ok = n_reg || z_reg;
            COND_NNEG:   cond_ok = !n_reg;
            default:     cond_ok = 1'b0;
        endcase
    end

    // Instructions that read or write a data word.
    assign is_rd = (opc == OP_LOAD) || (opc == OP_RET) || (opc == OP_POP);
    assign is_wr = (opc == OP_STORE) || (opc == OP_CALLC) || (opc == OP_CALLR) ||
                   (opc == OP_PUSH);

    // Memory address and write controls.
    always_comb
    begin
        maddr  = pc_reg[MEM_ADDR_BITS-1:0];
        mwdata = wdata_reg[7:0];
        mwe    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!operation)
                begin
                    maddr  = load_address[MEM_ADDR_BITS-1:0];
                    mwdata = load_byte;
                    mwe    = in_valid && in_ready;
                end
            end
            S_I0:    maddr = pc_reg[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(1);
            S_I1:    maddr = pc_reg[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(2);
            S_K0:    maddr = pc_reg[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(3);
            S_D0:    maddr = addr_reg[MEM_ADDR_BITS-1:0];
            S_D1:    maddr = addr_reg[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(1);
            S_W0:
            begin
                maddr = addr_reg[MEM_ADDR_BITS-1:0];
                mwe   = 1'b1;
            end
            S_W1:
            begin
                maddr  = addr_reg[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(1);
                mwdata = wdata_reg[15:8];
                mwe    = 1'b1;
            end
            default: ;
        endcase
    end

    // Program counter and result fields at retirement.
    always_comb
    begin
        pc_done   = pc_reg;
        st_done   = ST_RUN;
        outv_done = 1'b0;
        char_done = 8'd0;
        take_done = 1'b0;
        case (opc)
            OP_ILLEGAL: st_done = ST_ILLEGAL;
            OP_SET:     pc_done = pc_reg + 16'd4;
            OP_LOAD, OP_STORE: pc_done = pc_reg + (via_reg ? 16'd2 : 16'd4);
            OP_MOVE, OP_ALU, OP_PUSH, OP_POP: pc_done = pc_reg + 16'd2;
            OP_JMPC:    pc_done = cond_ok ? kval_reg : pc_reg + 16'd4;
            OP_JMPR:    pc_done = cond_ok ? rva : pc_reg + 16'd2;
            OP_CALLC:   pc_done = kval_reg;
            OP_CALLR:   pc_done = rva;
            OP_RET:     pc_done = dval_reg;
            OP_IN:
            begin
                pc_done   = pc_reg + 16'd2;
                take_done = !eof_reg;
            end
            OP_OUT:
            begin
                pc_done   = pc_reg + 16'd2;
                outv_done = 1'b1;
                char_done = rva[7:0];
            end
            default: st_done = ST_HALTED;
        endcase
    end

    // Sequencer registers, architectural state and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            sp_reg        <= '0;
            z_reg         <= 1'b0;
            n_reg         <= 1'b0;
            insn_reg      <= '0;
            kval_reg      <= '0;
            dval_reg      <= '0;
            addr_reg      <= '0;
            wdata_reg     <= '0;
            eof_reg       <= 1'b0;
            char_reg      <= '0;
            res_reg       <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // The result stays valid until it is taken.
            if ((state_reg == S_DONE) || (state_reg == S_WAIT))
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        eof_reg  <= in_eof;
                        char_reg <= in_char;
                    end
                end
                S_I0: insn_reg[7:0] <= mrdata_reg;
                S_I1: insn_reg[15:8] <= mrdata_reg;
                S_K0: kval_reg[7:0] <= mrdata_reg;
                S_K1: kval_reg[15:8] <= mrdata_reg;
                S_D1: dval_reg[7:0] <= mrdata_reg;
                S_D2: dval_reg[15:8] <= mrdata_reg;
                S_WAIT:
                begin
                    res_reg.status    <= ST_RUN;
                    res_reg.pc_after  <= pc_reg;
                    res_reg.out_valid <= 1'b0;
                    res_reg.out_char  <= '0;
                    res_reg.in_taken  <= 1'b0;
                end

                // Execute: set up the data address, store data and stack pointer.
                S_EXEC:
                begin
                    case (opc)
                        OP_LOAD:  addr_reg <= kaddr;
                        OP_STORE:
                        begin
                            addr_reg  <= kaddr;
                            wdata_reg <= rva;
                        end
                        OP_CALLC, OP_CALLR, OP_PUSH:
                        begin
                            addr_reg  <= sp_reg - 16'd2;
                            sp_reg    <= sp_reg - 16'd2;
                            wdata_reg <= (opc == OP_CALLC) ? pc_reg + 16'd4 :
                                         (opc == OP_CALLR) ? pc_reg + 16'd2 : rva;
                        end
                        OP_RET, OP_POP: addr_reg <= sp_reg;
                        default: ;
                    endcase
                end

                // Retire with all data in hand.
                S_DONE:
                begin
                    pc_reg            <= pc_done;
                    res_reg.status    <= st_done;
                    res_reg.pc_after  <= pc_done;
                    res_reg.out_valid <= outv_done;
                    res_reg.out_char  <= char_done;
                    res_reg.in_taken  <= take_done;
                    case (opc)
                        OP_SET: regs_reg[ra] <= kval_reg;
                        OP_LOAD:
                        begin
                            regs_reg[ra] <= byte_mode ? {8'd0, dval_reg[7:0]} : dval_reg;
                        end
                        OP_MOVE:
                        begin
                            if (insn_reg[3:0] == MOVE_SP && insn_reg[7:4] == MOVE_SP)
                            begin
                                // Nothing moves.
                            end
                            else if (insn_reg[3:0] == MOVE_SP)
                            begin
                                regs_reg[insn_reg[6:4]] <= sp_reg;
                            end
                            else if (insn_reg[7:4] == MOVE_SP)
                            begin
                                sp_reg <= regs_reg[insn_reg[2:0]];
                            end
                            else
                            begin
                                regs_reg[insn_reg[6:4]] <= regs_reg[insn_reg[2:0]];
                            end
                        end
                        OP_ALU:
                        begin
                            if (insn_reg[11:9] <= ALU_SHR)
                            begin
                                regs_reg[insn_reg[8:6]] <= alu_val;
                            end
                            z_reg <= (alu_val == 16'd0);
                            n_reg <= alu_val[15];
                        end
                        OP_RET: sp_reg <= sp_reg + 16'd2;
                        OP_POP:
                        begin
                            regs_reg[ra] <= dval_reg;
                            sp_reg       <= sp_reg + 16'd2;
                        end
                        OP_IN: regs_reg[ra] <= eof_reg ? 16'hFFFF : {8'd0, char_reg};
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = operation ? S_I0 : S_WAIT;
                end
            end
            S_I0:   state_next = S_I1;
            S_I1:   state_next = S_K0;
            S_K0:   state_next = S_K1;
            S_K1:   state_next = S_EXEC;
            S_EXEC:
            begin
                if (is_rd)
                begin
                    state_next = S_D0;
                end
                else if (is_wr)
                begin
                    state_next = S_W0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_D0:   state_next = S_D1;
            S_D1:   state_next = (opc == OP_LOAD && byte_mode) ? S_DONE : S_D2;
            S_D2:   state_next = S_DONE;
            S_W0:   state_next = (opc == OP_STORE && byte_mode) ? S_DONE : S_W1;
            S_W1:   state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            S_WAIT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE) && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign status    = res_reg.status;
    assign pc_after  = res_reg.pc_after;
    assign out_valid = res_reg.out_valid;
    assign out_char  = res_reg.out_char;
    assign in_taken  = res_reg.in_taken;
endmodule

### bench/tb_top.sv
// Self-checking testbench for the tiny 16-bit CPU core through its two channels.
module tb_top;
    import tcpu_pkg::*;

    // Jump condition codes.
    localparam logic [2:0] CC_ALWAYS = 3'd0;
    localparam logic [2:0] CC_ZERO   = 3'd1;
    localparam logic [2:0] CC_NZERO  = 3'd2;
    localparam logic [2:0] CC_NEG    = 3'd3;
    localparam logic [2:0] CC_GT     = 3'd4;
    localparam logic [2:0] CC_LE     = 3'd5;
    localparam logic [2:0] CC_NNEG   = 3'd6;

    localparam logic OPN_LOAD = 1'b0;
    localparam logic OPN_EXEC = 1'b1;

    localparam int TOTAL_ITEMS  = 1750;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DIR_ROWS     = 28;

    typedef struct packed {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [7:0]  ch;
        logic        eof;
    } cpu_req_t;

    typedef struct packed {
        logic [15:0] insn;
        logic [15:0] opnd;
        logic [7:0]  ch;
        logic        eof;
        logic        chk;
        logic [1:0]  st;
        logic [15:0] pc;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        operation;
    logic [15:0] load_address;
    logic [7:0]  load_byte;
    logic [7:0]  in_char;
    logic        in_eof;
    logic        res_valid;
    logic        res_ready;
    logic [1:0]  status;
    logic [15:0] pc_after;
    logic        out_valid;
    logic [7:0]  out_char;
    logic        in_taken;

    // Shadow copy of the core's architectural state.
    logic [7:0]  mem_img [0:65535];
    bit          mem_written [0:65535];
    logic [15:0] gpr [0:7];
    logic [15:0] pc_q;
    logic [15:0] sp_q;
    logic        zf_q;
    logic        nf_q;

    cpu_req_t    request_q [$];
    result_t     result_q [$];
    dir_row_t    dir_tab [0:DIR_ROWS-1];

    int          errors;
    int          cycles;
    int          send_idle;
    int          recv_idle;
    bit          hold_req;
    int          hold_cnt;

    tiny_16bit_cpu_core_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .load_address(load_address), .load_byte(load_byte),
        .in_char(in_char), .in_eof(in_eof),
        .res_valid(res_valid), .res_ready(res_ready),
        .status(status), .pc_after(pc_after), .out_valid(out_valid),
        .out_char(out_char), .in_taken(in_taken)
    );

    // Clock with a period of 8.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [7:0] rd8(logic [15:0] a);
        return mem_img[a];
    endfunction

    function automatic logic [15:0] rd16(logic [15:0] a);
        logic [15:0] a1;
        a1 = a + 16'd1;
        return {mem_img[a1], mem_img[a]};
    endfunction

    function automatic void wr8(logic [15:0] a, logic [7:0] v);
        mem_img[a] = v;
        mem_written[a] = 1'b1;
    endfunction

    function automatic void wr16(logic [15:0] a, logic [15:0] v);
        wr8(a, v[7:0]);
        wr8(a + 16'd1, v[15:8]);
    endfunction

    function automatic bit cond_met(logic [2:0] cc);
        case (cc)
            CC_ALWAYS: return 1'b1;
            CC_ZERO:   return zf_q;
            CC_NZERO:  return !zf_q;
            CC_NEG:    return nf_q;
            CC_GT:     return !nf_q && !zf_q;
            CC_LE:     return nf_q || zf_q;
            CC_NNEG:   return !nf_q;
            default:   return 1'b0;
        endcase
    endfunction

    // Executes one request on the shadow state and returns the result it causes.
    function automatic result_t cpu_step(cpu_req_t r);
        result_t     res;
        logic [15:0] insn;
        logic [15:0] pc;
        logic [15:0] addr;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] val;
        logic [2:0]  ra;
        logic [2:0]  rb;
        logic [2:0]  sel;
        logic [3:0]  src;
        logic [3:0]  dst;
        bit          via;
        res = '0;
        pc = pc_q;
        if (r.op == OPN_LOAD)
        begin
            wr8(r.addr, r.data);
        end
        else
        begin
            insn = rd16(pc);
            ra = insn[2:0];
            rb = insn[5:3];
            via = insn[11];
            addr = via ? gpr[rb] : rd16(pc + 16'd2);
            case (insn[15:12])
                OP_ILLEGAL: res.status = ST_ILLEGAL;
                OP_SET:
                begin
                    gpr[ra] = rd16(pc + 16'd2);
                    pc = pc + 16'd4;
                end
                OP_LOAD:
                begin
                    gpr[ra] = insn[10] ? {8'h00, rd8(addr)} : rd16(addr);
                    pc = pc + (via ? 16'd2 : 16'd4);
                end
                OP_STORE:
                begin
                    if (insn[10])
                        wr8(addr, gpr[ra][7:0]);
                    else
                        wr16(addr, gpr[ra]);
                    pc = pc + (via ? 16'd2 : 16'd4);
                end
                OP_MOVE:
                begin
                    src = insn[3:0];
                    dst = insn[7:4];
                    if (src == MOVE_SP && dst == MOVE_SP)
                        ;
                    else if (src == MOVE_SP)
                        gpr[dst[2:0]] = sp_q;
                    else if (dst == MOVE_SP)
                        sp_q = gpr[src[2:0]];
                    else
                        gpr[dst[2:0]] = gpr[src[2:0]];
                    pc = pc + 16'd2;
                end
                OP_ALU:
                begin
                    a = gpr[ra];
                    b = gpr[rb];
                    sel = insn[11:9];
                    case (sel)
                        ALU_ADD: val = a + b;
                        ALU_SUB: val = a - b;
                        ALU_AND: val = a & b;
                        ALU_OR:  val = a | b;
                        ALU_XOR: val = a ^ b;
                        ALU_SHR: val = (b >= 16) ? 16'd0 : (a >> b);
                        ALU_CMP: val = a - b;
                        default: val = a;
                    endcase
                    if (sel != ALU_CMP && sel != ALU_TEST)
                        gpr[insn[8:6]] = val;
                    zf_q = (val == 16'd0);
                    nf_q = val[15];
                    pc = pc + 16'd2;
                end
                OP_JMPC: pc = cond_met(insn[11:9]) ? rd16(pc + 16'd2) : pc + 16'd4;
                OP_JMPR: pc = cond_met(insn[11:9]) ? gpr[ra] : pc + 16'd2;
                OP_CALLC:
                begin
                    sp_q = sp_q - 16'd2;
                    wr16(sp_q, pc + 16'd4);
                    pc = rd16(pc + 16'd2);
                end
                OP_CALLR:
                begin
                    sp_q = sp_q - 16'd2;
                    wr16(sp_q, pc + 16'd2);
                    pc = gpr[ra];
                end
                OP_RET:
                begin
                    pc = rd16(sp_q);
                    sp_q = sp_q + 16'd2;
                end
                OP_PUSH:
                begin
                    sp_q = sp_q - 16'd2;
                    wr16(sp_q, gpr[ra]);
                    pc = pc + 16'd2;
                end
                OP_POP:
                begin
                    gpr[ra] = rd16(sp_q);
                    sp_q = sp_q + 16'd2;
                    pc = pc + 16'd2;
                end
                OP_IN:
                begin
                    if (r.eof)
                        gpr[ra] = 16'hFFFF;
                    else
                    begin
                        gpr[ra] = {8'h00, r.ch};
                        res.in_taken = 1'b1;
                    end
                    pc = pc + 16'd2;
                end
                OP_OUT:
                begin
                    res.out_valid = 1'b1;
                    res.out_char = gpr[ra][7:0];
                    pc = pc + 16'd2;
                end
                default: res.status = ST_HALTED;
            endcase
            pc_q = pc;
        end
        res.pc_after = pc_q;
        return res;
    endfunction

    // Queues one request with its expected result.
    task automatic add_request(cpu_req_t r, bit typed, result_t tv);
        result_t res;
        res = cpu_step(r);
        request_q.push_back(r);
        result_q.push_back(typed ? tv : res);
    endtask

    task automatic put_byte(logic [15:0] a, logic [7:0] v);
        cpu_req_t r;
        r.op = OPN_LOAD;
        r.addr = a;
        r.data = v;
        r.ch = 8'($urandom);
        r.eof = 1'($urandom);
        add_request(r, 1'b0, '0);
    endtask

    task automatic fill_if_unwritten(logic [15:0] a);
        if (!mem_written[a])
            put_byte(a, 8'($urandom));
    endtask

    // Places one instruction at the PC, backs every byte it reads, then executes it.
    task automatic run_insn(logic [15:0] insn, logic [15:0] opnd, logic [7:0] ch,
                            logic eof, bit typed, result_t tv);
        cpu_req_t    r;
        logic [15:0] addr;
        bit          has_opnd;
        has_opnd = (insn[15:12] == OP_SET) || (insn[15:12] == OP_JMPC) ||
                   (insn[15:12] == OP_CALLC) ||
                   ((insn[15:12] == OP_LOAD || insn[15:12] == OP_STORE) && !insn[11]);
        put_byte(pc_q, insn[7:0]);
        put_byte(pc_q + 16'd1, insn[15:8]);
        if (has_opnd)
        begin
            put_byte(pc_q + 16'd2, opnd[7:0]);
            put_byte(pc_q + 16'd3, opnd[15:8]);
        end
        if (insn[15:12] == OP_LOAD)
        begin
            addr = insn[11] ? gpr[insn[5:3]] : opnd;
            fill_if_unwritten(addr);
            if (!insn[10])
                fill_if_unwritten(addr + 16'd1);
        end
        if (insn[15:12] == OP_RET || insn[15:12] == OP_POP)
        begin
            fill_if_unwritten(sp_q);
            fill_if_unwritten(sp_q + 16'd1);
        end
        r.op = OPN_EXEC;
        r.addr = 16'($urandom);
        r.data = 8'($urandom);
        r.ch = ch;
        r.eof = eof;
        add_request(r, typed, tv);
    endtask

    // Builds the whole request stream and its expected results.
    task automatic build_stimulus();
        result_t     tv;
        logic [3:0]  opc;
        int          pick;
        dir_tab = '{
            '{16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1, ST_ILLEGAL, 16'h0000},
            '{16'hF000, 16'h0000, 8'h00, 1'b0, 1'b1, ST_HALTED,  16'h0000},
            '{16'h1001, 16'hFFFF, 8'h00, 1'b0, 1'b1, ST_RUN,     16'h0004},
            '{16'h1002, 16'h8000, 8'h00, 1'b0, 1'b1, ST_RUN,     16'h0008},
            '{16'h50D1, 16'h0000, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h52D1, 16'h0000, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h54D1, 16'h0000, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h56D1, 16'h0000, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h58D1, 16'h0000, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h5AD1, 16'h0000, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h5CD1, 16'h0000, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h5ED1, 16'h0000, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h4081, 16'h0000, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h4048, 16'h0000, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h4088, 16'h0000, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h40F9, 16'h0000, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h3001, 16'h1234, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h3C09, 16'h0000, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h3809, 16'h0000, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h2003, 16'h1234, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h2C0A, 16'h0000, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h6E00, 16'h0100, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h6000, 16'h0200, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'h8000, 16'h0300, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'hA000, 16'h0000, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'hB001, 16'h0000, 8'h00, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'hD003, 16'h0000, 8'hFF, 1'b0, 1'b0, ST_RUN, 16'h0},
            '{16'hE003, 16'h0000, 8'h00, 1'b1, 1'b0, ST_RUN, 16'h0}
        };
        // Directed part: every opcode but JMPR, POP and CALLR, the register and shift extremes, address wrap.
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            tv = '0;
            tv.status = dir_tab[i].st;
            tv.pc_after = dir_tab[i].pc;
            run_insn(dir_tab[i].insn, dir_tab[i].opnd, dir_tab[i].ch, dir_tab[i].eof,
                     dir_tab[i].chk, tv);
        end
        // A few more directed steps: POP, IN at end of input, call through a register.
        run_insn(16'hC002, 16'h0000, 8'h00, 1'b0, 1'b0, '0);
        run_insn(16'hD004, 16'h0000, 8'h5A, 1'b1, 1'b0, '0);
        run_insn(16'h9001, 16'h0000, 8'h00, 1'b0, 1'b0, '0);
        // Random programs: mostly valid instructions, some stray byte writes.
        while (request_q.size() < TOTAL_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                put_byte(16'($urandom), 8'($urandom));
            else
            begin
                if (pick < 11)
                    opc = OP_ILLEGAL;
                else if (pick < 13)
                    opc = OP_HALT;
                else
                    opc = 4'($urandom_range(1, 14));
                run_insn({opc, 12'($urandom)}, 16'($urandom), 8'($urandom),
                         ($urandom_range(3) == 0), 1'b0, '0);
            end
        end
    endtask

    // Sender: offers requests in order and applies the idle mix of each phase.
    initial
    begin
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = 1'b0;
        load_address = '0;
        load_byte = '0;
        in_char = '0;
        in_eof = 1'b0;
        res_ready = 1'b0;
        errors = 0;
        hold_req = 1'b0;
        send_idle = 32;
        recv_idle = 70;
        for (int i = 0; i < 65536; i++)
        begin
            mem_img[i] = 8'h00;
            mem_written[i] = 1'b0;
        end
        for (int i = 0; i < 8; i++)
            gpr[i] = '0;
        pc_q = '0;
        sp_q = '0;
        zf_q = 1'b0;
        nf_q = 1'b0;
        build_stimulus();
        n = request_q.size();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 3)
            begin
                send_idle = 70;
                recv_idle = 32;
            end
            else if (i == (2 * n) / 3)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            while ($urandom_range(99) < send_idle)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            operation <= request_q[i].op;
            load_address <= request_q[i].addr;
            load_byte <= request_q[i].data;
            in_char <= request_q[i].ch;
            in_eof <= request_q[i].eof;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            if (i == 100)
                hold_req = 1'b1;
            @(negedge clk);
        end
        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off while the sender keeps offering requests.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt = hold_cnt - 1;
                res_ready <= 1'b0;
            end
            else
                res_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial hold_cnt = 0;

    // Result checker: compares each delivered result with the oldest expectation.
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && res_valid && res_ready)
        begin
            if (result_q.size() == 0)
            begin
                $error("unexpected result: status %0d pc_after %h", status, pc_after);
                errors++;
            end
            else
            begin
                e = result_q.pop_front();
                if (status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, status);
                    errors++;
                end
                if (pc_after !== e.pc_after)
                begin
                    $error("pc_after: expected %h, got %h", e.pc_after, pc_after);
                    errors++;
                end
                if (out_valid !== e.out_valid)
                begin
                    $error("out_valid: expected %0d, got %0d", e.out_valid, out_valid);
                    errors++;
                end
                if (out_char !== e.out_char)
                begin
                    $error("out_char: expected %h, got %h", e.out_char, out_char);
                    errors++;
                end
                if (in_taken !== e.in_taken)
                begin
                    $error("in_taken: expected %0d, got %0d", e.in_taken, in_taken);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

### sim.f
hw/rtl/tcpu_pkg.sv
hw/rtl/tcpu_alu.sv
hw/rtl/tiny_16bit_cpu_core_top.sv
bench/tb_top.sv
